### hdl/pscs_pkg.sv
// Package: shared widths and types for the point set center and scale block.
`default_nettype none
package pscs_pkg;
    localparam int unsigned CoordW = 24;
    localparam int unsigned NormW  = 16;
    localparam int unsigned DiffW  = 25;
    localparam int unsigned SumW   = 31;
    localparam int unsigned Dist2W = 52;
    localparam int unsigned RootW  = 26;
    localparam int unsigned PointW = 3 * CoordW;
    localparam logic [1:0]  DimTwo = 2'd2;
    localparam logic [1:0]  DimRst = 2'd3;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [NormW-1:0]  t_norm;
    typedef logic signed [DiffW-1:0]  t_diff;
    typedef logic signed [SumW-1:0]   t_sum;
endpackage
`default_nettype wire

### hdl/pscs_point_if.sv
// Interfaces: input point channel, result channel and configuration channel.
`default_nettype none
interface pscs_point_if
    import pscs_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord coord_x;
    t_coord coord_y;
    t_coord coord_z;
    logic   last_point;
    modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface pscs_norm_if
    import pscs_pkg::*;
();
    logic  valid;
    logic  ready;
    t_norm norm_x;
    t_norm norm_y;
    t_norm norm_z;
    logic  last_result;
    modport source (output valid, norm_x, norm_y, norm_z, last_result, input ready);
    modport sink   (input valid, norm_x, norm_y, norm_z, last_result, output ready);
endinterface

interface pscs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### hdl/pscs_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module pscs_ram #(
    parameter int unsigned WIDTH = 72,
    parameter int unsigned DEPTH = 64
) (
    input  wire                                         i_clk,
    input  wire                                         i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                             i_wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/point_set_center_and_scale_top.sv
// Top level: point set centering and max-radius scaling.
//
// Usage: point requests enter on i_pt (valid/ready), one point per cycle
// while loading. Each point is written to a point memory and added to
// running sums. Points beyond MAX_NODES are dropped but still accepted.
// A request with last_point set starts a pass:
//   - centroid: three serial signed divides of the sums by the count;
//   - max pass: one memory read per cycle, distance squared through a
//     two-stage multiply pipeline;
//   - root: bit-serial integer square root;
//   - emit pass: per point one memory read, a capture of the centered values,
//     three serial divides of |d| * 16384 by the radius and a hand-off to
//     the output register; the next point is read only after that hand-off.
// Results leave on o_res through an output register; while the receiver
// stalls the register holds and the pass waits. No request is accepted
// during a pass. The dimensions register (i_cfg) is sampled at the start
// of a pass; reset sets it to three dimensions and clears sums and count.
`default_nettype none
module point_set_center_and_scale_top
    import pscs_pkg::*;
#(
    parameter int unsigned MAX_NODES = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pscs_point_if.sink   i_pt,
    pscs_cfg_if.sink     i_cfg,
    pscs_norm_if.source  o_res
);
    localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned CW = $clog2(MAX_NODES + 1);
    localparam int unsigned QW = 41;   // quotient/dividend width

    typedef enum logic [3:0] {
        S_LOAD, S_CDIV, S_MRD, S_MAX, S_SQRT, S_ERD, S_EWAIT, S_EDIV, S_EOUT
    } t_state;

    t_state r_state;
    logic [1:0]  r_dim;
    logic        r_two;
    t_sum        r_sum_x, r_sum_y, r_sum_z;
    logic [CW-1:0] r_cnt;
    t_coord      r_cx, r_cy, r_cz;
    logic [Dist2W-1:0] r_max;
    logic [RootW-1:0]  r_root;
    logic [1:0]  r_sel;
    logic [AW:0] r_idx;

    // divider state (shared restoring divider)
    logic [QW-1:0] r_quo;
    logic [QW:0]   r_rem;
    logic [QW-1:0] r_den;
    logic [5:0]    r_step;
    logic          r_neg;

    // memory
    logic [PointW-1:0] w_rdata;
    logic [AW-1:0]     w_raddr;
    logic              w_we;
    assign w_we    = (r_state == S_LOAD) && i_pt.valid && i_pt.ready
                     && ({1'b0, r_cnt} < (CW+1)'(MAX_NODES));
    assign w_raddr = r_idx[AW-1:0];

    pscs_ram #(.WIDTH(PointW), .DEPTH(MAX_NODES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({i_pt.coord_z, i_pt.coord_y, i_pt.coord_x}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // centered coordinates of the point read
    t_diff w_dx, w_dy, w_dz;
    assign w_dx = t_diff'($signed(w_rdata[CoordW-1:0])) - t_diff'(r_cx);
    assign w_dy = t_diff'($signed(w_rdata[2*CoordW-1:CoordW])) - t_diff'(r_cy);
    assign w_dz = r_two ? '0 :
                  t_diff'($signed(w_rdata[3*CoordW-1:2*CoordW])) - t_diff'(r_cz);

    // full-width squares of the centered coordinates
    logic signed [2*DiffW-1:0] w_px, w_py, w_pz;
    assign w_px = w_dx * w_dx;
    assign w_py = w_dy * w_dy;
    assign w_pz = w_dz * w_dz;

    // distance-squared pipeline: square then sum
    logic [2*DiffW-1:0] r_sqx, r_sqy, r_sqz;
    logic               r_sq_v, r_d2_v;
    logic [Dist2W-1:0]  r_d2;
    logic               r_rd_v;

    // held centered values for the emit pass
    t_diff r_ex, r_ey, r_ez;
    t_norm r_nx, r_ny, r_nz;

    // sqrt state
    logic [Dist2W-1:0] r_srem;
    logic [Dist2W-1:0] r_sval;
    logic [4:0]        r_sstep;
    logic [RootW+1:0]  w_trial;
    logic [RootW+1:0]  w_srem_sh;
    assign w_srem_sh = {r_srem[RootW-1:0], r_sval[Dist2W-1 -: 2]};
    assign w_trial   = {r_root, 2'b01};

    // divider step
    logic [QW:0] w_rsh;
    assign w_rsh = {r_rem[QW-1:0], r_quo[QW-1]};

    // selected dividend sign/magnitude for the current divide
    t_sum  w_csum;
    t_diff w_ed;
    always_comb begin
        unique case (r_sel)
            2'd0:    w_csum = r_sum_x;
            2'd1:    w_csum = r_sum_y;
            default: w_csum = r_sum_z;
        endcase
        unique case (r_sel)
            2'd0:    w_ed = r_ex;
            2'd1:    w_ed = r_ey;
            default: w_ed = r_ez;
        endcase
    end

    logic w_out_free;
    assign w_out_free = !o_res.valid || o_res.ready;
    assign i_pt.ready = (r_state == S_LOAD);
    assign i_cfg.ready = 1'b1;

    logic [QW-1:0] w_q;
    assign w_q = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        // squaring pipeline payload
        r_sqx <= $unsigned(w_px);
        r_sqy <= $unsigned(w_py);
        r_sqz <= $unsigned(w_pz);
        r_d2  <= Dist2W'(r_sqx) + Dist2W'(r_sqy) + Dist2W'(r_sqz);
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_dim   <= DimRst;
            r_two   <= 1'b0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
            r_cnt   <= '0;
            r_max   <= '0;
            r_idx   <= '0;
            r_sel   <= '0;
            r_rd_v  <= 1'b0;
            r_sq_v  <= 1'b0;
            r_d2_v  <= 1'b0;
            o_res.valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_dim <= i_cfg.data;
            end
            r_sq_v <= r_rd_v;
            r_d2_v <= r_sq_v;
            unique case (r_state)
                // accumulate points; start the pass on the last one
                S_LOAD: begin
                    if (i_pt.valid) begin
                        if (w_we) begin
                            r_sum_x <= r_sum_x + t_sum'(i_pt.coord_x);
                            r_sum_y <= r_sum_y + t_sum'(i_pt.coord_y);
                            r_sum_z <= r_sum_z + t_sum'(i_pt.coord_z);
                            r_cnt   <= r_cnt + 1'b1;
                        end
                        if (i_pt.last_point && (w_we || r_cnt != '0)) begin
                            r_two  <= (r_dim == DimTwo);
                            r_sel  <= 2'd0;
                            r_state <= S_CDIV;
                            r_step <= '0;
                        end
                    end
                end
                // centroid: signed sum / count, serial restoring divide
                S_CDIV: begin
                    if (r_step == '0) begin
                        r_neg <= w_csum[SumW-1];
                        r_quo <= QW'(w_csum[SumW-1] ? -w_csum : w_csum);
                        r_rem <= '0;
                        r_den <= QW'(r_cnt);
                        r_step <= 6'd1;
                    end else if (r_step <= 6'(QW)) begin
                        if (w_rsh >= {1'b0, r_den}) begin
                            r_rem <= w_rsh - {1'b0, r_den};
                            r_quo <= {r_quo[QW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_quo <= {r_quo[QW-2:0], 1'b0};
                        end
                        r_step <= r_step + 1'b1;
                    end else begin
                        unique case (r_sel)
                            2'd0:    r_cx <= t_coord'(w_q);
                            2'd1:    r_cy <= t_coord'(w_q);
                            default: r_cz <= t_coord'(w_q);
                        endcase
                        r_step <= '0;
                        if (r_sel == 2'd2) begin
                            r_state <= S_MRD;
                            r_idx   <= '0;
                            r_max   <= '0;
                        end else begin
                            r_sel <= r_sel + 1'b1;
                        end
                    end
                end
                // issue reads for the max pass
                S_MRD: begin
                    r_rd_v <= 1'b1;
                    r_idx  <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == (AW+1)'(r_cnt)) begin
                        r_state <= S_MAX;
                    end
                end
                // drain the pipeline and keep the maximum
                S_MAX: begin
                    r_rd_v <= 1'b0;
                    if (!r_rd_v && !r_sq_v && !r_d2_v) begin
                        r_state <= S_SQRT;
                        r_srem  <= '0;
                        r_sval  <= r_max;
                        r_root  <= '0;
                        r_sstep <= '0;
                    end
                end
                // bit-serial square root, two radicand bits a step
                S_SQRT: begin
                    if (w_srem_sh >= w_trial) begin
                        r_srem <= Dist2W'(w_srem_sh - w_trial);
                        r_root <= {r_root[RootW-2:0], 1'b1};
                    end else begin
                        r_srem <= Dist2W'(w_srem_sh);
                        r_root <= {r_root[RootW-2:0], 1'b0};
                    end
                    r_sval  <= {r_sval[Dist2W-3:0], 2'b00};
                    r_sstep <= r_sstep + 1'b1;
                    if (r_sstep == 5'(RootW - 1)) begin
                        r_state <= S_ERD;
                        r_idx   <= '0;
                    end
                end
                // read one point
                S_ERD: begin
                    r_state <= S_EWAIT;
                end
                S_EWAIT: begin
                    r_ex <= w_dx;
                    r_ey <= w_dy;
                    r_ez <= w_dz;
                    r_sel <= 2'd0;
                    r_step <= '0;
                    r_state <= S_EDIV;
                end
                // |d| * 16384 / r per coordinate
                S_EDIV: begin
                    if (r_step == '0) begin
                        r_neg <= w_ed[DiffW-1];
                        r_quo <= {QW'(w_ed[DiffW-1] ? -w_ed : w_ed)} << 14;
                        r_rem <= '0;
                        r_den <= QW'(r_root);
                        r_step <= 6'd1;
                    end else if (r_step <= 6'(QW)) begin
                        if (w_rsh >= {1'b0, r_den}) begin
                            r_rem <= w_rsh - {1'b0, r_den};
                            r_quo <= {r_quo[QW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_quo <= {r_quo[QW-2:0], 1'b0};
                        end
                        r_step <= r_step + 1'b1;
                    end else begin
                        r_step <= '0;
                        if (r_sel == 2'd0) begin
                            r_nx <= (r_den == '0) ? '0 : t_norm'(w_q);
                        end else if (r_sel == 2'd1) begin
                            r_ny <= (r_den == '0) ? '0 : t_norm'(w_q);
                        end
                        if (r_sel == 2'd2) begin
                            r_nz <= (r_den == '0) ? '0 : t_norm'(w_q);
                            r_state <= S_EOUT;
                        end else begin
                            r_sel <= r_sel + 1'b1;
                        end
                    end
                end
                // hand the result to the output register
                S_EOUT: begin
                    if (w_out_free) begin
                        o_res.norm_x <= r_nx;
                        o_res.norm_y <= r_ny;
                        o_res.norm_z <= r_nz;
                        o_res.last_result <= (r_idx + 1'b1 == (AW+1)'(r_cnt));
                        if (r_idx + 1'b1 == (AW+1)'(r_cnt)) begin
                            r_state <= S_LOAD;
                            r_sum_x <= '0;
                            r_sum_y <= '0;
                            r_sum_z <= '0;
                            r_cnt   <= '0;
                            r_idx   <= '0;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
            // load the output register, or drop the accepted result
            if (r_state == S_EOUT && w_out_free) begin
                o_res.valid <= 1'b1;
            end else if (o_res.ready) begin
                o_res.valid <= 1'b0;
            end
            // keep the running maximum
            if (r_d2_v && r_d2 > r_max) begin
                r_max <= r_d2;
            end
        end
    end
endmodule
`default_nettype wire

### sim/tb_point_set_center_and_scale_top.sv
// Testbench: point set centering and max-radius scaling against a built-in predictor.
`default_nettype none
module tb_point_set_center_and_scale_top
    import pscs_pkg::*;
();

    localparam int unsigned MaxNodes   = 64;
    localparam int unsigned CycleLimit = 4000000;

    typedef struct packed {
        t_norm nx;
        t_norm ny;
        t_norm nz;
        logic  last;
    } t_norm_rec;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   last;
        logic   has_exp;
        t_norm  ex;
        t_norm  ey;
        t_norm  ez;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    int   cycle_cnt;
    int   err_cnt;

    pscs_point_if pt_if();
    pscs_norm_if  res_if();
    pscs_cfg_if   cfg_if();

    point_set_center_and_scale_top #(.MAX_NODES(MaxNodes)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_res   (res_if.source)
    );

    // Predictor state: stored points, count and the dimensions register
    longint    set_x[MaxNodes];
    longint    set_y[MaxNodes];
    longint    set_z[MaxNodes];
    int        set_count;
    logic [1:0] dims_reg;
    t_norm_rec norm_expected[$];
    t_stim_row dir_rows[$];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle counter and timeout
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CycleLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic longint isqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic t_norm scale_diff(longint d, longint r);
        longint q;
        if (r == 0) return '0;
        q = ((d < 0 ? -d : d) * 16384) / r;
        return t_norm'(d < 0 ? -q : q);
    endfunction

    // Add one point to the set; on the last point compute the normalized set
    task automatic predict_point(t_coord x, t_coord y, t_coord z, logic last);
        longint sx, sy, sz, cx, cy, cz, dx, dy, dz, d2, max_d2, rad;
        logic two_d;
        t_norm_rec rec;
        if (set_count < MaxNodes) begin
            set_x[set_count] = x;
            set_y[set_count] = y;
            set_z[set_count] = z;
            set_count++;
        end
        if (!last || set_count == 0) return;
        two_d = (dims_reg == DimTwo);
        sx = 0; sy = 0; sz = 0;
        for (int i = 0; i < set_count; i++) begin
            sx += set_x[i]; sy += set_y[i]; sz += set_z[i];
        end
        cx = sx / set_count;
        cy = sy / set_count;
        cz = two_d ? 0 : sz / set_count;
        max_d2 = 0;
        for (int i = 0; i < set_count; i++) begin
            dx = set_x[i] - cx;
            dy = set_y[i] - cy;
            dz = two_d ? 0 : set_z[i] - cz;
            d2 = dx * dx + dy * dy + dz * dz;
            if (d2 > max_d2) max_d2 = d2;
        end
        rad = isqrt(max_d2);
        for (int i = 0; i < set_count; i++) begin
            dx = set_x[i] - cx;
            dy = set_y[i] - cy;
            dz = two_d ? 0 : set_z[i] - cz;
            rec.nx = scale_diff(dx, rad);
            rec.ny = scale_diff(dy, rad);
            rec.nz = scale_diff(dz, rad);
            rec.last = (i + 1 == set_count);
            norm_expected = {norm_expected, rec};
        end
        set_count = 0;
    endtask

    // Send one point request after a random gap
    task automatic send_point(t_coord x, t_coord y, t_coord z, logic last);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_if.valid      <= 1'b1;
        pt_if.coord_x    <= x;
        pt_if.coord_y    <= y;
        pt_if.coord_z    <= z;
        pt_if.last_point <= last;
        do @(posedge i_clk); while (!pt_if.ready);
        predict_point(x, y, z, last);
    endtask

    // Write the dimensions register while the block is idle
    task automatic write_dims(logic [1:0] value);
        pt_if.valid <= 1'b0;
        while (norm_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        dims_reg = value;
    endtask

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 8191)) - t_coord'(4096);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return t_coord'($urandom_range(0, 200)) - t_coord'(100);
        endcase
    endfunction

    // Result receiver: random stalls, compare against the oldest expectation
    initial begin
        t_norm_rec got, exp_rec;
        int stall;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.norm_x, res_if.norm_y, res_if.norm_z, res_if.last_result};
                if (norm_expected.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("unexpected result %p", got);
                end else begin
                    exp_rec = norm_expected.pop_front();
                    if (got != exp_rec) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: expected %p got %p", exp_rec, got);
                    end
                end
                stall = (cycle_cnt % 3000 < 1000) ? 0 : $urandom_range(0, 9);
                if (stall != 0) begin
                    res_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    res_if.ready <= 1'b1;
                end
            end else if (!res_if.ready) begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        int set_len, mode, sent;
        t_stim_row row;
        t_norm_rec exp_rec;
        err_cnt = 0;
        set_count = 0;
        dims_reg = DimRst;
        i_rst_n <= 1'b0;
        pt_if.valid <= 1'b0;
        pt_if.coord_x <= '0;
        pt_if.coord_y <= '0;
        pt_if.coord_z <= '0;
        pt_if.last_point <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= DimRst;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: single point gives zero radius; extremes on an axis give +-1
        dir_rows = '{
            '{24'sd5, 24'sd7, 24'sd9, 1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0},
            '{24'sh7FFFFF, 24'sd0, 24'sd0, 1'b0, 1'b0, 0, 0, 0},
            '{24'sh800001, 24'sd0, 24'sd0, 1'b1, 1'b0, 0, 0, 0},
            '{24'sh800000, 24'sh800000, 24'sh800000, 1'b0, 1'b0, 0, 0, 0},
            '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 1'b0, 0, 0, 0},
            '{24'sh800000, 24'sh7FFFFF, 24'sd0, 1'b1, 1'b0, 0, 0, 0},
            '{24'sd3, 24'sd3, 24'sd3, 1'b0, 1'b0, 0, 0, 0},
            '{24'sd3, 24'sd3, 24'sd3, 1'b1, 1'b0, 0, 0, 0}
        };
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            send_point(row.x, row.y, row.z, row.last);
            if (row.has_exp) begin
                exp_rec = norm_expected[norm_expected.size() - 1];
                if (exp_rec.nx != row.ex || exp_rec.ny != row.ey || exp_rec.nz != row.ez) begin
                    err_cnt++;
                    $display("predictor disagrees with directed row %0d", k);
                end
            end
        end
        // Overfull store: 70 points, the dropped last one still starts the pass
        for (int i = 0; i < 70; i++)
            send_point(rand_coord(3), rand_coord(0), rand_coord(1), i == 69);

        // Two dimensions, then codes 0 and 1, which the block treats as three
        write_dims(DimTwo);
        send_point(24'sd100, 24'sd0, 24'sh7FFFFF, 1'b0);
        send_point(-24'sd100, 24'sd0, 24'sh800000, 1'b1);
        write_dims(2'd0);
        send_point(24'sd1, 24'sd2, 24'sd3, 1'b0);
        send_point(24'sd4, 24'sd5, 24'sd6, 1'b1);
        write_dims(2'd1);
        send_point(24'sd0, 24'sd0, 24'sd40, 1'b0);
        send_point(24'sd0, 24'sd0, -24'sd40, 1'b1);

        // Random sets of mostly small size with random content
        sent = 0;
        while (sent < 380) begin
            if (sent % 120 == 0) write_dims($urandom_range(0, 1) ? DimTwo : DimRst);
            set_len = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 66)
                                                   : $urandom_range(1, 8);
            mode = $urandom_range(0, 3);
            for (int i = 0; i < set_len; i++)
                send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                           i == set_len - 1);
            sent += set_len;
        end
        pt_if.valid <= 1'b0;

        while (norm_expected.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

### point_set_center_and_scale_top.f
hdl/pscs_pkg.sv
hdl/pscs_point_if.sv
hdl/pscs_ram.sv
hdl/point_set_center_and_scale_top.sv
sim/tb_point_set_center_and_scale_top.sv
